// ===== design/kct_pkg.sv =====
// Shared types and constants for the keyed count table.
`timescale 1ns / 1ps

package kct_pkg;

  // Fixed widths of the command and result words.
  localparam int unsigned CmdW   = 3;
  localparam int unsigned KeyW   = 8;
  localparam int unsigned AddW   = 16;
  localparam int unsigned StatW  = 3;
  localparam int unsigned ValueW = 16;
  localparam int unsigned OccW   = 7;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD    = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_INC    = 3'd2,
    CMD_DEC    = 3'd3,
    CMD_LOOKUP = 3'd4
  } kct_cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_DONE        = 3'd0,
    ST_ABSENT      = 3'd1,
    ST_PRESENT     = 3'd2,
    ST_FULL        = 3'd3,
    ST_DEC_REMOVED = 3'd4
  } kct_status_e;

  // Operation broadcast to every cell of the row.
  typedef enum logic [1:0] {
    OP_NONE      = 2'd0,
    OP_APPEND    = 2'd1,
    OP_SET_COUNT = 2'd2,
    OP_SHIFT     = 2'd3
  } kct_op_e;

  typedef struct packed {
    kct_op_e          op;
    logic [KeyW-1:0]  key;
  } kct_ctrl_t;

endpackage

// ===== design/kct_if.sv =====
// Valid/ready channel interfaces for commands and results.
`timescale 1ns / 1ps

interface kct_cmd_if;
  logic                  valid;
  logic                  ready;
  logic [kct_pkg::CmdW-1:0] command;
  logic [kct_pkg::KeyW-1:0] key;
  logic [kct_pkg::AddW-1:0] add_count;

  modport source (output valid, output command, output key, output add_count, input ready);
  modport sink   (input valid, input command, input key, input add_count, output ready);
endinterface

interface kct_res_if;
  logic                      valid;
  logic                      ready;
  logic [kct_pkg::StatW-1:0]  status;
  logic [kct_pkg::ValueW-1:0] count_value;
  logic [kct_pkg::OccW-1:0]   occupancy;

  modport source (output valid, output status, output count_value, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input count_value, input occupancy,
                  output ready);
endinterface

// ===== design/kct_cell.sv =====
// One entry of the table: key, count, match flag and shift-down logic.
`timescale 1ns / 1ps

module kct_cell import kct_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned USED_W     = 7,
  parameter int unsigned IDX        = 0
) (
  input  logic                  clk_i,
  input  logic                  cmp_en_i,
  input  logic [KeyW-1:0]       cmp_key_i,
  input  logic [USED_W-1:0]     used_i,
  input  kct_ctrl_t             ctrl_i,
  input  logic [COUNT_BITS-1:0] count_i,
  input  logic                  found_i,
  input  logic [KeyW-1:0]       next_key_i,
  input  logic [COUNT_BITS-1:0] next_count_i,
  output logic [KeyW-1:0]       key_o,
  output logic [COUNT_BITS-1:0] count_o,
  output logic                  hit_o,
  output logic [COUNT_BITS-1:0] hit_count_o,
  output logic                  found_o
);

  logic [KeyW-1:0]       key_q;
  logic [COUNT_BITS-1:0] count_q;
  logic                  hit_q;
  logic                  occupied;

  assign occupied    = used_i > USED_W'(IDX);
  assign key_o       = key_q;
  assign count_o     = count_q;
  assign hit_o       = hit_q;
  assign hit_count_o = hit_q ? count_q : '0;
  // The match and every entry above it take part in a shift down.
  assign found_o     = found_i | hit_q;

  always_ff @(posedge clk_i) begin
    if (cmp_en_i) begin
      hit_q <= occupied && (key_q == cmp_key_i);
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_APPEND: begin
        if (used_i == USED_W'(IDX)) begin
          key_q   <= ctrl_i.key;
          count_q <= count_i;
        end
      end
      OP_SET_COUNT: begin
        if (hit_q) begin
          count_q <= count_i;
        end
      end
      OP_SHIFT: begin
        if (found_o) begin
          key_q   <= next_key_i;
          count_q <= next_count_i;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/keyed_count_table.sv =====
// Top level of the keyed count table: command decode, cell row and result register.
`timescale 1ns / 1ps

// The block keeps an ordered table of up to ENTRIES distinct byte keys, each with a
// saturating count of COUNT_BITS bits, in a row of cells. Each command word goes
// through a compare step and an apply step: at the edge that accepts it every cell
// compares its key with the command's key, and in the apply step that follows the
// matching count is gathered, the result is formed and the row is updated (append at
// the end, count update in place, or a shift down of every entry above a removed
// one). The command channel is ready again only once the apply step is done, so no
// new command word is accepted before the last one has passed the row. A finished
// result sits in an output register, and the block only stalls in its apply step
// when that register still holds a result that has not been taken. Every command
// yields exactly one result word carrying the status, the key's count and the
// occupancy afterwards. Entries are not cleared at reset; only the fill count is,
// and cells above it are never read.
module keyed_count_table import kct_pkg::*; #(
  parameter int unsigned ENTRIES    = 64,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kct_cmd_if.sink   cmd_i,
  kct_res_if.source res_o
);

  localparam int unsigned UsedW = $clog2(ENTRIES + 1);
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_APPLY = 2'b10
  } kct_state_e;

  kct_state_e state_q, state_d;

  logic [CmdW-1:0]  cmd_q;
  logic [KeyW-1:0]  key_q;
  logic [AddW-1:0]  add_q;
  logic [UsedW-1:0] used_q, used_d;

  logic accept;
  logic out_free;
  logic apply;

  // Cell row wiring.
  logic [KeyW-1:0]       key_a      [ENTRIES];
  logic [COUNT_BITS-1:0] count_a    [ENTRIES];
  logic [KeyW-1:0]       nkey_a     [ENTRIES];
  logic [COUNT_BITS-1:0] ncount_a   [ENTRIES];
  logic [COUNT_BITS-1:0] hitcount_a [ENTRIES];
  logic                  hit_a      [ENTRIES];
  logic                  found_a    [ENTRIES+1];

  kct_ctrl_t             ctrl;
  logic [COUNT_BITS-1:0] wr_count;

  logic                  any_hit;
  logic [COUNT_BITS-1:0] hit_count;

  kct_status_e           status;
  logic [COUNT_BITS-1:0] value;
  logic [COUNT_BITS-1:0] add_sat;
  logic [31:0]           add_wide;
  logic [31:0]           value_wide;
  logic [31:0]           used_wide;

  logic                  out_valid_q;
  logic [StatW-1:0]      status_q;
  logic [ValueW-1:0]     value_q;
  logic [OccW-1:0]       occ_q;

  assign cmd_i.ready = (state_q == S_IDLE);
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign out_free    = !out_valid_q || res_o.ready;
  assign apply       = (state_q == S_APPLY) && out_free;

  // Each cell compares its key at the accepting edge; the results are used in the apply step.
  assign found_a[0] = 1'b0;

  for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_cell
    if (gi == ENTRIES - 1) begin : g_last
      assign nkey_a[gi]   = key_a[gi];
      assign ncount_a[gi] = count_a[gi];
    end else begin : g_mid
      assign nkey_a[gi]   = key_a[gi+1];
      assign ncount_a[gi] = count_a[gi+1];
    end

    kct_cell #(
      .COUNT_BITS (COUNT_BITS),
      .USED_W     (UsedW),
      .IDX        (gi)
    ) u_cell (
      .clk_i        (clk_i),
      .cmp_en_i     (accept),
      .cmp_key_i    (cmd_i.key),
      .used_i       (used_q),
      .ctrl_i       (ctrl),
      .count_i      (wr_count),
      .found_i      (found_a[gi]),
      .next_key_i   (nkey_a[gi]),
      .next_count_i (ncount_a[gi]),
      .key_o        (key_a[gi]),
      .count_o      (count_a[gi]),
      .hit_o        (hit_a[gi]),
      .hit_count_o  (hitcount_a[gi]),
      .found_o      (found_a[gi+1])
    );
  end

  // Keys are unique, so at most one cell matches and a plain OR gathers its count.
  always_comb begin
    any_hit   = 1'b0;
    hit_count = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      any_hit   = any_hit | hit_a[i];
      hit_count = hit_count | hitcount_a[i];
    end
  end

  // The initial count of an add saturates at the largest count the cells hold.
  always_comb begin
    add_wide = 32'(add_q);
    if (add_wide > 32'(CountMax)) begin
      add_sat = CountMax;
    end else begin
      add_sat = add_wide[COUNT_BITS-1:0];
    end
  end

  // Command decode for the apply step.
  always_comb begin
    ctrl.op  = OP_NONE;
    ctrl.key = key_q;
    wr_count = add_sat;
    status   = ST_DONE;
    value    = '0;
    used_d   = used_q;

    case (cmd_q)
      CMD_ADD: begin
        if (any_hit) begin
          status = ST_PRESENT;
          value  = hit_count;
        end else if (used_q == UsedW'(ENTRIES)) begin
          status = ST_FULL;
        end else begin
          ctrl.op = OP_APPEND;
          value   = add_sat;
          used_d  = used_q + UsedW'(1);
        end
      end
      CMD_REMOVE: begin
        if (!any_hit) begin
          status = ST_ABSENT;
        end else begin
          ctrl.op = OP_SHIFT;
          used_d  = used_q - UsedW'(1);
        end
      end
      CMD_INC: begin
        if (!any_hit) begin
          status = ST_ABSENT;
        end else begin
          ctrl.op  = OP_SET_COUNT;
          wr_count = (hit_count != CountMax) ? hit_count + COUNT_BITS'(1) : hit_count;
          value    = wr_count;
        end
      end
      CMD_DEC: begin
        if (!any_hit) begin
          status = ST_ABSENT;
        end else if (hit_count == '0) begin
          // A decrement of a zero count drops the entry altogether.
          ctrl.op = OP_SHIFT;
          status  = ST_DEC_REMOVED;
          used_d  = used_q - UsedW'(1);
        end else begin
          ctrl.op  = OP_SET_COUNT;
          wr_count = hit_count - COUNT_BITS'(1);
          value    = wr_count;
        end
      end
      default: begin
        // Lookup, and any unknown command treated as one.
        if (!any_hit) begin
          status = ST_ABSENT;
        end else begin
          value = hit_count;
        end
      end
    endcase

    if (!apply) begin
      ctrl.op = OP_NONE;
    end
  end

  assign value_wide = 32'(value);
  assign used_wide  = 32'(used_d);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        if (apply) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (apply) begin
        used_q      <= used_d;
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i.command;
      key_q <= cmd_i.key;
      add_q <= cmd_i.add_count;
    end
    if (apply) begin
      status_q <= status;
      value_q  <= value_wide[ValueW-1:0];
      occ_q    <= used_wide[OccW-1:0];
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.status      = status_q;
  assign res_o.count_value = value_q;
  assign res_o.occupancy   = occ_q;

endmodule

// ===== design/kct_checker.sv =====
// Port-level checks for the keyed count table, bound to the top level.
`timescale 1ns / 1ps

module kct_checker import kct_pkg::*; #(
  parameter int unsigned ENTRIES = 64
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              cmd_valid_i,
  input logic              cmd_ready_i,
  input logic              res_valid_i,
  input logic              res_ready_i,
  input logic [StatW-1:0]  res_status_i,
  input logic [ValueW-1:0] res_value_i,
  input logic [OccW-1:0]   res_occ_i
);

  // A held result word keeps its contents until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_status_i)
      && $stable(res_value_i) && $stable(res_occ_i))
    else $error("result word changed while stalled");

  // Only one command is worked on at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> !cmd_ready_i)
    else $error("command accepted while another is in flight");

  // Statuses that leave no entry behind report a zero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_status_i == ST_ABSENT || res_status_i == ST_FULL
      || res_status_i == ST_DEC_REMOVED) |-> res_value_i == '0)
    else $error("non-zero count with absent, full or removed status");

  // The table never reports more entries than it holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> 32'(res_occ_i) <= ENTRIES)
    else $error("occupancy above table size");

endmodule

bind keyed_count_table kct_checker #(
  .ENTRIES (ENTRIES)
) u_kct_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cmd_valid_i  (cmd_i.valid),
  .cmd_ready_i  (cmd_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_status_i (res_o.status),
  .res_value_i  (res_o.count_value),
  .res_occ_i    (res_o.occupancy)
);
